[rtl/mlr_pkg.sv]
package mlr_pkg;

    // Default pixel coordinate width; the screen may be at most 2^COORD_BITS pixels wide.
    localparam int COORD_BITS_DEF = 12;

    // Fixed widths of the item fields and configuration registers.
    localparam int IN_COORD_BITS  = 14;
    localparam int SIZE_BITS      = 13;
    localparam int REG_INDEX_BITS = 1;

    // Screen sizes after reset.
    localparam int SCREEN_WIDTH_RST  = 640;
    localparam int SCREEN_HEIGHT_RST = 480;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    // Hand-over of the registered input item to the line walker.
    typedef struct packed {
        logic fire;   // the walker takes the item in this cycle
        logic start;  // the item begins a new line
    } stage_ctl_t;

endpackage

[rtl/mlr_clamp.sv]
module mlr_clamp
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic signed [IN_COORD_BITS-1:0] coord,
    input  logic        [COORD_BITS-1:0]    limit,
    output logic        [COORD_BITS-1:0]    clamped
);

    localparam int CW = ((IN_COORD_BITS > COORD_BITS) ? IN_COORD_BITS : COORD_BITS) + 1;

    logic [CW-1:0] mag;
    logic [CW-1:0] limit_ext;

    assign mag       = CW'(coord[IN_COORD_BITS-2:0]);
    assign limit_ext = CW'(limit);

    always_comb
    begin
        if (coord[IN_COORD_BITS-1])
        begin
            clamped = '0;
        end
        else if (mag > limit_ext)
        begin
            clamped = limit;
        end
        else
        begin
            clamped = mag[COORD_BITS-1:0];
        end
    end

endmodule

[rtl/mlr_walk.sv]
module mlr_walk
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stage_ctl_t            ctl,
    input  logic [COORD_BITS-1:0] first_x,
    input  logic [COORD_BITS-1:0] first_y,
    input  logic [COORD_BITS-1:0] final_x,
    input  logic [COORD_BITS-1:0] final_y,
    output logic                  res_free,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y,
    output logic                  res_last
);

    localparam int SW = COORD_BITS + 1;   // span and signed difference width
    localparam int DW = COORD_BITS + 3;   // decision variable width

    logic                  active_reg, active_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] stop_x_reg, stop_x_next;
    logic [COORD_BITS-1:0] stop_y_reg, stop_y_next;
    logic signed [DW-1:0]  decision_reg, decision_next;
    logic [SW-1:0]         span_x_reg, span_x_next;
    logic [SW-1:0]         span_y_reg, span_y_next;
    logic                  steep_reg, steep_next;
    logic                  step_x_neg_reg, step_x_neg_next;
    logic                  step_y_neg_reg, step_y_neg_next;

    logic                  res_valid_reg, res_valid_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next;
    logic [COORD_BITS-1:0] res_y_reg, res_y_next;
    logic                  res_last_reg, res_last_next;

    // Set-up of a new line.
    logic [SW-1:0]        dx, dy;
    logic [SW-1:0]        init_span_x, init_span_y;
    logic                 init_steep;
    logic signed [DW-1:0] init_decision;

    // One step along the current line.
    logic                  at_end;
    logic                  dec_pos;
    logic                  produce;
    logic signed [DW-1:0]  two_minor, two_major, step_decision;
    logic [COORD_BITS-1:0] x_moved, y_moved;

    assign dx          = {1'b0, final_x} - {1'b0, first_x};
    assign dy          = {1'b0, final_y} - {1'b0, first_y};
    assign init_span_x = dx[SW-1] ? (~dx + SW'(1)) : dx;
    assign init_span_y = dy[SW-1] ? (~dy + SW'(1)) : dy;
    assign init_steep  = init_span_y > init_span_x;

    always_comb
    begin
        if (init_steep)
        begin
            init_decision = signed'(DW'({init_span_x, 1'b0})) - signed'(DW'(init_span_y));
        end
        else
        begin
            init_decision = signed'(DW'({init_span_y, 1'b0})) - signed'(DW'(init_span_x));
        end
    end

    assign at_end    = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
    assign dec_pos   = !decision_reg[DW-1] && (decision_reg != '0);
    assign produce   = ctl.fire && !ctl.start && active_reg;
    assign two_minor = signed'(DW'({steep_reg ? span_x_reg : span_y_reg, 1'b0}));
    assign two_major = signed'(DW'({steep_reg ? span_y_reg : span_x_reg, 1'b0}));
    assign step_decision = decision_reg + two_minor - (dec_pos ? two_major : DW'(0));
    assign x_moved = step_x_neg_reg ? (cur_x_reg - COORD_BITS'(1)) : (cur_x_reg + COORD_BITS'(1));
    assign y_moved = step_y_neg_reg ? (cur_y_reg - COORD_BITS'(1)) : (cur_y_reg + COORD_BITS'(1));

    always_comb
    begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        stop_x_next     = stop_x_reg;
        stop_y_next     = stop_y_reg;
        decision_next   = decision_reg;
        span_x_next     = span_x_reg;
        span_y_next     = span_y_reg;
        steep_next      = steep_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;

        if (ctl.fire && ctl.start)
        begin
            active_next     = 1'b1;
            cur_x_next      = first_x;
            cur_y_next      = first_y;
            stop_x_next     = final_x;
            stop_y_next     = final_y;
            decision_next   = init_decision;
            span_x_next     = init_span_x;
            span_y_next     = init_span_y;
            steep_next      = init_steep;
            step_x_neg_next = dx[SW-1];
            step_y_neg_next = dy[SW-1];
        end
        else if (produce)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                decision_next = step_decision;
                if (steep_reg)
                begin
                    cur_y_next = y_moved;
                    if (dec_pos)
                    begin
                        cur_x_next = x_moved;
                    end
                end
                else
                begin
                    cur_x_next = x_moved;
                    if (dec_pos)
                    begin
                        cur_y_next = y_moved;
                    end
                end
            end
        end
    end

    assign res_free = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_last_next  = res_last_reg;
        if (produce)
        begin
            res_valid_next = 1'b1;
            res_x_next     = cur_x_reg;
            res_y_next     = cur_y_reg;
            res_last_next  = at_end;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            stop_x_reg     <= '0;
            stop_y_reg     <= '0;
            decision_reg   <= '0;
            span_x_reg     <= '0;
            span_y_reg     <= '0;
            steep_reg      <= 1'b0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            res_valid_reg  <= res_valid_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            stop_x_reg     <= stop_x_next;
            stop_y_reg     <= stop_y_next;
            decision_reg   <= decision_next;
            span_x_reg     <= span_x_next;
            span_y_reg     <= span_y_next;
            steep_reg      <= steep_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_last_reg <= res_last_next;
    end

    assign res_valid = res_valid_reg;
    assign res_x     = res_x_reg;
    assign res_y     = res_y_reg;
    assign res_last  = res_last_reg;

    // The walker never takes an item while a result it cannot replace is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.fire && !res_free))
    else $error("item taken while the result register is full");

    // A start always leaves a line in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.start |=> active_reg)
    else $error("start did not open a line");

    // The end pixel closes the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        produce && at_end |=> !active_reg)
    else $error("line still open after its end pixel");

    // Every step on an open line gives a result whose last flag matches the end test.
    assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> res_valid_reg && (res_last_reg == $past(at_end)))
    else $error("step result missing or last flag wrong");

endmodule

[rtl/midpoint_line_rasterizer_core.sv]
// Midpoint line rasterizer. A start item (tuser low) carries two signed pixel endpoints,
// which are clamped to the screen set by the two size registers and become the new
// line; it gives no result and drops any line still in progress. Each step item
// (tuser high) then returns one pixel, starting with the start point, and the end
// point comes out with tlast set, after which the block is idle and further steps
// return nothing until the next start. The block takes one item in every clock
// cycle: a step is a single add-and-compare on the decision variable held in the
// line walker, so its rate is set by that one update. A result passes through the
// input register and then the result register after its step item is taken, and
// backpressure on the result side stalls the input only once both registers are full.
module midpoint_line_rasterizer_core
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Item input.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Bits from 0 up: start_x, start_y, end_x, end_y (14 bits each, signed).
    input  logic [4*IN_COORD_BITS-1:0] s_tdata,
    // Bit 0: opcode (0 starts a line, 1 steps one pixel).
    input  logic                      s_tuser,

    // Pixel output.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Bits from 0 up: out_x, out_y (COORD_BITS each), zero padding to whole bytes.
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic                      m_tlast,

    // Configuration write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [REG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]      cfg_data
);

    localparam int TDW = ((2*COORD_BITS+7)/8)*8;
    // Working width for comparing a size register with the largest screen.
    localparam int LW  = ((SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1) + 1;
    localparam int CAP = 1 << COORD_BITS;
    localparam int LIM_W_RST = ((SCREEN_WIDTH_RST > CAP) ? CAP : SCREEN_WIDTH_RST) - 1;
    localparam int LIM_H_RST = ((SCREEN_HEIGHT_RST > CAP) ? CAP : SCREEN_HEIGHT_RST) - 1;

    // The size registers are kept as the largest legal coordinate, which is what the
    // clamps need. A size of zero behaves as one, and a size beyond the coordinate
    // range behaves as the full range.
    logic [COORD_BITS-1:0] lim_x_reg, lim_x_next;
    logic [COORD_BITS-1:0] lim_y_reg, lim_y_next;
    logic [LW-1:0]         size_ext;
    logic [LW-1:0]         cap_ext;
    logic [LW-1:0]         new_limit;

    assign cfg_ready = 1'b1;
    assign size_ext  = LW'(cfg_data);
    assign cap_ext   = LW'(CAP);

    always_comb
    begin
        if (size_ext == '0)
        begin
            new_limit = '0;
        end
        else if (size_ext > cap_ext)
        begin
            new_limit = cap_ext - LW'(1);
        end
        else
        begin
            new_limit = size_ext - LW'(1);
        end
    end

    always_comb
    begin
        lim_x_next = lim_x_reg;
        lim_y_next = lim_y_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SCREEN_WIDTH:  lim_x_next = new_limit[COORD_BITS-1:0];
                REG_SCREEN_HEIGHT: lim_y_next = new_limit[COORD_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_x_reg <= COORD_BITS'(LIM_W_RST);
            lim_y_reg <= COORD_BITS'(LIM_H_RST);
        end
        else
        begin
            lim_x_reg <= lim_x_next;
            lim_y_reg <= lim_y_next;
        end
    end

    // Input register: the endpoints are clamped on the way in, so the walker sees
    // screen coordinates only.
    logic [COORD_BITS-1:0] clamp_sx, clamp_sy, clamp_ex, clamp_ey;

    mlr_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_sx
    (
        .coord   (signed'(s_tdata[IN_COORD_BITS-1:0])),
        .limit   (lim_x_reg),
        .clamped (clamp_sx)
    );

    mlr_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_sy
    (
        .coord   (signed'(s_tdata[2*IN_COORD_BITS-1:IN_COORD_BITS])),
        .limit   (lim_y_reg),
        .clamped (clamp_sy)
    );

    mlr_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_ex
    (
        .coord   (signed'(s_tdata[3*IN_COORD_BITS-1:2*IN_COORD_BITS])),
        .limit   (lim_x_reg),
        .clamped (clamp_ex)
    );

    mlr_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_ey
    (
        .coord   (signed'(s_tdata[4*IN_COORD_BITS-1:3*IN_COORD_BITS])),
        .limit   (lim_y_reg),
        .clamped (clamp_ey)
    );

    logic                  in_valid_reg, in_valid_next;
    logic                  in_start_reg;
    logic [COORD_BITS-1:0] in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;
    logic                  in_take;
    logic                  res_free;
    stage_ctl_t            walk_ctl;

    // The input register moves on whenever the walker can take its item, so an item
    // is accepted every cycle unless both stages are holding.
    assign walk_ctl.fire  = in_valid_reg && res_free;
    assign walk_ctl.start = in_start_reg;
    assign s_tready       = !in_valid_reg || res_free;
    assign in_take        = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (walk_ctl.fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_start_reg <= (opcode_t'(s_tuser) == OP_START);
            in_sx_reg    <= clamp_sx;
            in_sy_reg    <= clamp_sy;
            in_ex_reg    <= clamp_ex;
            in_ey_reg    <= clamp_ey;
        end
    end

    // Line walker with its result register.
    logic [COORD_BITS-1:0] res_x, res_y;

    mlr_walk #(.COORD_BITS(COORD_BITS)) u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (walk_ctl),
        .first_x   (in_sx_reg),
        .first_y   (in_sy_reg),
        .final_x   (in_ex_reg),
        .final_y   (in_ey_reg),
        .res_free  (res_free),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_last  (m_tlast)
    );

    assign m_tdata = TDW'({res_y, res_x});

endmodule

[tb/sv/midpoint_line_rasterizer_core_test.sv]
`timescale 1ns / 1ps

module midpoint_line_rasterizer_core_test;
    import mlr_pkg::*;

    // The block is used with its default coordinate width, so a pixel result
    // is two 12-bit coordinates packed into 24 bits of m_tdata.
    localparam int CB            = COORD_BITS_DEF;
    localparam int PIX_BITS      = ((2 * CB + 7) / 8) * 8;
    // A result passes the input and the result register after its step item, and a start
    // item must pass the input register to reach the line walker, so these quiet cycles
    // make sure that nothing is left in flight before the screen size is changed.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          last;
    } pixel_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    // Bits from 0 up: start_x, start_y, end_x, end_y (14 bits each, signed).
    logic [4*IN_COORD_BITS-1:0]   s_tdata = '0;
    // Bit 0: opcode.
    logic                         s_tuser = OP_START;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // Bits from 0 up: out_x, out_y.
    logic [PIX_BITS-1:0]          m_tdata;
    logic                         m_tlast;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [REG_INDEX_BITS-1:0]    cfg_index = REG_SCREEN_WIDTH;
    logic [SIZE_BITS-1:0]         cfg_data = '0;

    midpoint_line_rasterizer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Our own copy of the screen size registers and of the line walker.
    logic [SIZE_BITS-1:0]   scr_width  = SIZE_BITS'(SCREEN_WIDTH_RST);
    logic [SIZE_BITS-1:0]   scr_height = SIZE_BITS'(SCREEN_HEIGHT_RST);
    logic                   ln_active  = 1'b0;
    logic [CB-1:0]          ln_x       = '0;
    logic [CB-1:0]          ln_y       = '0;
    logic [CB-1:0]          ln_end_x   = '0;
    logic [CB-1:0]          ln_end_y   = '0;
    // The decision variable is kept doubled, so the half-pixel test is exact.
    logic signed [14:0]     ln_err     = '0;
    logic [12:0]            ln_run_x   = '0;
    logic [12:0]            ln_run_y   = '0;
    logic                   ln_steep   = 1'b0;
    logic                   ln_x_back  = 1'b0;
    logic                   ln_y_back  = 1'b0;

    // Pixels that the walker must still produce, oldest first.
    pixel_t pending_pixels[$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    // Items that did something: starts and steps of a line in progress.
    int  work_items  = 0;
    // Whether each side inserts random waits; toggled so that there are
    // stretches at full rate as well as stretches with gaps and stalls.
    bit  send_gaps   = 1'b1;
    bit  recv_gaps   = 1'b1;
    int  stall_left  = 0;

    // A size of zero behaves as one pixel, and anything above the coordinate
    // range is capped at 2^CB.
    function automatic int usable_size(input logic [SIZE_BITS-1:0] s);
        int v;
        v = s;
        if (v == 0)
            v = 1;
        if (v > (1 << CB))
            v = 1 << CB;
        return v;
    endfunction

    function automatic int clamp_coord(input logic signed [IN_COORD_BITS-1:0] c,
                                       input int size);
        int v;
        v = c;
        if (v < 0)
            return 0;
        if (v > size - 1)
            return size - 1;
        return v;
    endfunction

    // Applies one accepted item to the walker copy and returns 1 with the
    // pixel when the item produces one.
    function automatic bit predict_pixel(input opcode_t op,
                                         input logic signed [IN_COORD_BITS-1:0] ax,
                                         input logic signed [IN_COORD_BITS-1:0] ay,
                                         input logic signed [IN_COORD_BITS-1:0] bx,
                                         input logic signed [IN_COORD_BITS-1:0] by,
                                         output pixel_t px);
        int w, h, dx, dy, step_x, step_y, e;
        px = '0;
        if (op == OP_START)
        begin
            w = usable_size(scr_width);
            h = usable_size(scr_height);
            ln_x      = CB'(clamp_coord(ax, w));
            ln_y      = CB'(clamp_coord(ay, h));
            ln_end_x  = CB'(clamp_coord(bx, w));
            ln_end_y  = CB'(clamp_coord(by, h));
            dx        = int'(ln_end_x) - int'(ln_x);
            dy        = int'(ln_end_y) - int'(ln_y);
            ln_x_back = dx < 0;
            ln_y_back = dy < 0;
            ln_run_x  = 13'(ln_x_back ? -dx : dx);
            ln_run_y  = 13'(ln_y_back ? -dy : dy);
            ln_steep  = ln_run_y > ln_run_x;
            e = ln_steep ? 2 * int'(ln_run_x) - int'(ln_run_y)
                         : 2 * int'(ln_run_y) - int'(ln_run_x);
            ln_err    = e[14:0];
            ln_active = 1'b1;
            return 1'b0;
        end
        // A step with no line in progress is ignored.
        if (!ln_active)
            return 1'b0;
        px.x    = ln_x;
        px.y    = ln_y;
        px.last = (ln_x == ln_end_x) && (ln_y == ln_end_y);
        if (px.last)
        begin
            ln_active = 1'b0;
            return 1'b1;
        end
        step_x = ln_x_back ? -1 : 1;
        step_y = ln_y_back ? -1 : 1;
        e = ln_err;
        // The minor axis steps only when the midpoint lies strictly past the
        // line; a decision of exactly zero keeps it where it is.
        if (ln_steep)
        begin
            if (e > 0)
            begin
                ln_x = CB'(int'(ln_x) + step_x);
                e -= 2 * int'(ln_run_y);
            end
            e += 2 * int'(ln_run_x);
            ln_y = CB'(int'(ln_y) + step_y);
        end
        else
        begin
            if (e > 0)
            begin
                ln_y = CB'(int'(ln_y) + step_y);
                e -= 2 * int'(ln_run_x);
            end
            e += 2 * int'(ln_run_y);
            ln_x = CB'(int'(ln_x) + step_x);
        end
        ln_err = e[14:0];
        return 1'b1;
    endfunction

    // Offers one item, holding it until the block takes it, and records the
    // pixel that it should produce. A following item with no gap keeps
    // s_tvalid high, so the valid is never dropped and raised in one step.
    task automatic send_item(input opcode_t op,
                             input logic signed [IN_COORD_BITS-1:0] ax,
                             input logic signed [IN_COORD_BITS-1:0] ay,
                             input logic signed [IN_COORD_BITS-1:0] bx,
                             input logic signed [IN_COORD_BITS-1:0] by);
        int     gap;
        pixel_t px;
        gap = send_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {by, bx, ay, ax};
        do @(posedge clk); while (!s_tready);
        if (predict_pixel(op, ax, ay, bx, by, px))
        begin
            pending_pixels = {pending_pixels, px};
            work_items++;
        end
        else if (op == OP_START)
            work_items++;
    endtask

    task automatic send_step();
        send_item(OP_STEP, 14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom));
    endtask

    // Stops offering items and waits until every pixel has arrived and the
    // pipeline has run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [SIZE_BITS-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            scr_width = value;
        else
            scr_height = value;
    endtask

    // A coordinate for the current screen: mostly inside it, sometimes just
    // around one of its edges, sometimes anywhere in the signed field.
    function automatic logic signed [IN_COORD_BITS-1:0] pick_coord(
            input logic [SIZE_BITS-1:0] size);
        int sz, r;
        sz = usable_size(size);
        r  = $urandom_range(0, 9);
        if (r < 7)
            return IN_COORD_BITS'($urandom_range(0, sz - 1));
        else if (r == 7)
            return IN_COORD_BITS'(sz + int'($urandom_range(0, 3)) - 2);
        else if (r == 8)
            return IN_COORD_BITS'(int'($urandom_range(0, 2)) - 1);
        return IN_COORD_BITS'($urandom);
    endfunction

    function automatic logic signed [IN_COORD_BITS-1:0] near_coord(
            input logic signed [IN_COORD_BITS-1:0] c);
        return IN_COORD_BITS'(int'(c) + int'($urandom_range(0, 24)) - 12);
    endfunction

    // Random traffic for the present screen size. Most of it is whole lines:
    // a start followed by steps up to the end pixel, at times a few idle
    // steps beyond it, at times cut short by the next start. The rest is
    // loose steps and starts with arbitrary endpoints.
    task automatic drive_random_lines(input int n_items);
        int target, left, steps, kind;
        logic signed [IN_COORD_BITS-1:0] ax, ay, bx, by;
        target = work_items + n_items;
        while (work_items < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_gaps = $urandom_range(0, 2) != 0;
                recv_gaps = $urandom_range(0, 2) != 0;
            end
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                ax = pick_coord(scr_width);
                ay = pick_coord(scr_height);
                bx = near_coord(ax);
                by = near_coord(ay);
                if ($urandom_range(0, 7) == 0)
                    bx = pick_coord(scr_width);
                if ($urandom_range(0, 7) == 0)
                    by = pick_coord(scr_height);
                send_item(OP_START, ax, ay, bx, by);
                left  = (ln_run_x > ln_run_y ? int'(ln_run_x) : int'(ln_run_y)) + 1;
                steps = left > 40 ? 40 : left;
                kind  = $urandom_range(0, 19);
                if (kind < 3)
                    steps += $urandom_range(1, 3);
                else if (kind < 5)
                    steps = $urandom_range(0, steps);
                repeat (steps) send_step();
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 3)) send_step();
            end
            else
            begin
                send_item(OP_START, 14'($urandom), 14'($urandom),
                          14'($urandom), 14'($urandom));
                repeat ($urandom_range(0, 6)) send_step();
            end
        end
    endtask

    // Hand-picked lines on the screen size that the block has after reset.
    task automatic test_directed_cases();
        // A step before any start has no line to walk.
        send_item(OP_STEP, 14'sh2000, 14'sh1FFF, 14'sh2000, 14'sh1FFF);
        // Equal endpoints: a single pixel flagged as last, then idle again.
        send_item(OP_START, 14'sd5, 14'sd7, 14'sd5, 14'sd7);
        send_step();
        send_step();
        // The most negative and most positive coordinates clamp to opposite
        // corners; the line is dropped part way by the next start.
        send_item(OP_START, 14'sh2000, 14'sh1FFF, 14'sh1FFF, 14'sh2000);
        repeat (3) send_step();
        // Here the midpoint of the second pixel lies exactly on the line.
        send_item(OP_START, 14'sd10, 14'sd10, 14'sd12, 14'sd11);
        repeat (4) send_step();
        // A steep line running towards smaller x and y.
        send_item(OP_START, 14'sd20, 14'sd20, 14'sd18, 14'sd15);
        repeat (7) send_step();
        // Everything clamps onto the origin.
        send_item(OP_START, 14'sd0, -14'sd1, -14'sd1, 14'sd0);
        send_step();
    endtask

    task automatic test_default_screen();
        drive_random_lines(250);
    endtask

    // The size registers at their limits: one pixel, zero (taken as one),
    // the largest screen, and values beyond it that are capped.
    task automatic test_screen_extremes();
        write_reg(REG_SCREEN_WIDTH, 13'd1);
        write_reg(REG_SCREEN_HEIGHT, 13'd1);
        drive_random_lines(80);
        write_reg(REG_SCREEN_WIDTH, 13'd0);
        write_reg(REG_SCREEN_HEIGHT, 13'h1FFF);
        drive_random_lines(150);
        write_reg(REG_SCREEN_WIDTH, 13'h1FFF);
        write_reg(REG_SCREEN_HEIGHT, 13'd0);
        drive_random_lines(150);
        write_reg(REG_SCREEN_WIDTH, 13'd4096);
        write_reg(REG_SCREEN_HEIGHT, 13'd4096);
        drive_random_lines(250);
    endtask

    task automatic test_random_screen();
        repeat (3)
        begin
            write_reg(REG_SCREEN_WIDTH, SIZE_BITS'($urandom_range(1, 4096)));
            write_reg(REG_SCREEN_HEIGHT, SIZE_BITS'($urandom_range(1, 4096)));
            drive_random_lines(100);
        end
    endtask

    // Result side: each pixel is checked against the oldest expectation, and, while
    // recv_gaps is set, m_tready is lowered for a random number of cycles after each one.
    always @(posedge clk)
    begin
        pixel_t        want;
        logic [CB-1:0] got_x;
        logic [CB-1:0] got_y;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_x = m_tdata[CB-1:0];
            got_y = m_tdata[2*CB-1:CB];
            if (pending_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pixel: x=%0d y=%0d last=%0b",
                             got_x, got_y, m_tlast);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got_x !== want.x || got_y !== want.y || m_tlast !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: want x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 want.x, want.y, want.last, got_x, got_y, m_tlast);
                end
            end
            stall_left = recv_gaps ? $urandom_range(0, 4) : 0;
            m_tready <= (stall_left == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_default_screen();
        test_screen_extremes();
        test_random_screen();

        settle();
        if (pending_pixels.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
